// ===== hdl/sph_pkg.sv =====
// Shared types, constants and the radix power table for the site pattern histogram.
// No dependencies; used by site_pattern_histogram and sph_checker.
package sph_pkg;

    localparam int SYM_BITS  = 2;
    localparam int IDX_BITS  = 16;
    localparam int OUT_BITS  = 32;
    localparam int RAD_BITS  = 3;
    localparam int SPC_BITS  = 4;
    localparam int CFG_BITS  = 4;
    localparam int IN_SLOTS  = 8;
    localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

    typedef enum logic {
        MODE_COUNT = 1'b0,
        MODE_READ  = 1'b1
    } t_mode;

    typedef enum logic {
        REG_ALPHABET_SIZE = 1'b0,
        REG_SPECIES_COUNT = 1'b1
    } t_reg;

    // radix^e modulo 2^16, radix already clamped to 2..4
    function automatic logic [IDX_BITS-1:0] f_pow(input logic [RAD_BITS-1:0] radix,
                                                  input logic [SPC_BITS-1:0] e);
        logic [IDX_BITS-1:0] p;
        p = '0;
        case (radix)
            3'd2: p = IDX_BITS'(1) << e;
            3'd4: p = IDX_BITS'(1) << {e, 1'b0};
            3'd3: begin
                case (e)
                    4'd0:  p = 16'd1;
                    4'd1:  p = 16'd3;
                    4'd2:  p = 16'd9;
                    4'd3:  p = 16'd27;
                    4'd4:  p = 16'd81;
                    4'd5:  p = 16'd243;
                    4'd6:  p = 16'd729;
                    4'd7:  p = 16'd2187;
                    4'd8:  p = 16'd6561;
                    4'd9:  p = 16'd19683;
                    4'd10: p = 16'd59049;
                    4'd11: p = 16'd46075;
                    4'd12: p = 16'd7153;
                    4'd13: p = 16'd21459;
                    4'd14: p = 16'd64377;
                    4'd15: p = 16'd62059;
                    default: p = '0;
                endcase
            end
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/site_pattern_histogram.sv =====
// Path: an accepted request passes stage 1, stage 2, stage 3 and the output register to m_axis.
// Throughput: one request per cycle while m_axis_tready does not stall the pipe; the bin memory
// read-modify-write loop (registered read, increment, write back with one-deep forwarding) sets it.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to all
// 65536 bins, one per cycle, with s_axis_tready low; config writes are taken.
module site_pattern_histogram #(
    parameter int MAX_SPECIES = 8,
    parameter int COUNT_BITS  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,   // column_symbols, bin_index
    input  logic                            s_axis_tuser,   // mode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [63:0]                     m_axis_tdata,   // bin_count, total_columns
    output logic                            m_axis_tuser,   // bad_symbol
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [sph_pkg::CFG_BITS-1:0]    i_cfg_data
);
    import sph_pkg::*;

    localparam int DEPTH  = 2 ** IDX_BITS;
    localparam int SLOTS  = (MAX_SPECIES > IN_SLOTS) ? MAX_SPECIES : IN_SLOTS;
    localparam int WIDE   = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS + 1;

    function automatic logic [OUT_BITS-1:0] f_out(input logic [COUNT_BITS-1:0] v);
        logic [WIDE-1:0] ext;
        ext = WIDE'(v);
        return (ext > WIDE'(OUT_MAX)) ? OUT_MAX : ext[OUT_BITS-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] f_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    // config
    logic [RAD_BITS-1:0] r_alpha;
    logic [SPC_BITS-1:0] r_spec;
    logic [RAD_BITS-1:0] radix;
    logic [SPC_BITS-1:0] ns;

    // clearing pass
    logic                r_clr_busy;
    logic [IDX_BITS-1:0] r_clr_addr;

    // stage 1: weighted digits
    logic                r_p1_valid;
    t_mode               r_p1_mode;
    logic                r_p1_bad;
    logic [IDX_BITS-1:0] r_p1_bidx;
    logic [IDX_BITS-1:0] r_p1_term [MAX_SPECIES];

    // stage 2: address, memory read
    logic                r_p2_valid;
    t_mode               r_p2_mode;
    logic                r_p2_bad;
    logic [IDX_BITS-1:0] r_p2_addr;

    // stage 3: modify, write back
    logic                  r_p3_valid;
    t_mode                 r_p3_mode;
    logic                  r_p3_bad;
    logic [IDX_BITS-1:0]   r_p3_addr;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_fwd;
    logic [COUNT_BITS-1:0] r_fwd_data;
    logic [COUNT_BITS-1:0] r_total;

    // output
    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_count;
    logic [OUT_BITS-1:0] r_out_total;
    logic                r_out_bad;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];

    logic out_free, p3_move, p3_free, p2_move, p2_free, p1_move, p1_free, in_acc;
    logic [2*SLOTS-1:0]    sym_pad;
    logic [IDX_BITS-1:0]   n_term [MAX_SPECIES];
    logic                  n_bad;
    logic [IDX_BITS-1:0]   n_sum;
    logic [IDX_BITS-1:0]   n_p2_addr;
    logic [COUNT_BITS-1:0] base, n_count, n_total;
    logic                  do_write;
    logic [OUT_BITS-1:0]   n_out_count;
    logic [OUT_BITS-1:0]   n_out_total;
    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    // handshake chain
    assign out_free      = !r_out_valid || m_axis_tready;
    assign p3_move       = r_p3_valid && out_free;
    assign p3_free       = !r_p3_valid || out_free;
    assign p2_move       = r_p2_valid && p3_free;
    assign p2_free       = !r_p2_valid || p3_free;
    assign p1_move       = r_p1_valid && p2_free;
    assign p1_free       = !r_p1_valid || p2_free;
    assign s_axis_tready = p1_free && !r_clr_busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_total, r_out_count};
    assign m_axis_tuser  = r_out_bad;

    // clamped config
    always_comb begin
        if (r_alpha < RAD_BITS'(2)) begin
            radix = RAD_BITS'(2);
        end else if (r_alpha > RAD_BITS'(4)) begin
            radix = RAD_BITS'(4);
        end else begin
            radix = r_alpha;
        end
        if (r_spec == '0) begin
            ns = SPC_BITS'(1);
        end else if (r_spec > SPC_BITS'(MAX_SPECIES)) begin
            ns = SPC_BITS'(MAX_SPECIES);
        end else begin
            ns = r_spec;
        end
    end

    // per-species digit weights; species 0 is most significant
    always_comb begin
        logic [SYM_BITS-1:0] s;
        logic [IDX_BITS-1:0] p;
        logic                used;
        sym_pad = (2*SLOTS)'(s_axis_tdata[IDX_BITS-1:0]);
        n_bad   = 1'b0;
        for (int j = 0; j < MAX_SPECIES; j++) begin
            s    = sym_pad[SYM_BITS*j +: SYM_BITS];
            used = SPC_BITS'(j) < ns;
            p    = f_pow(radix, ns - SPC_BITS'(j) - SPC_BITS'(1));
            n_term[j] = used ? (({IDX_BITS{s[0]}} & p) + ({IDX_BITS{s[1]}} & (p << 1)))
                             : '0;
            if (used && (RAD_BITS'(s) >= radix)) begin
                n_bad = 1'b1;
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int j = 0; j < MAX_SPECIES; j++) begin
            n_sum = n_sum + r_p1_term[j];
        end
        n_p2_addr = (r_p1_mode == MODE_READ) ? r_p1_bidx : n_sum;
    end

    // modify
    always_comb begin
        base     = r_fwd ? r_fwd_data : r_rd_data;
        n_count  = f_inc(base);
        n_total  = f_inc(r_total);
        do_write = r_p3_valid && (r_p3_mode == MODE_COUNT) && !r_p3_bad;
        if (r_p3_mode == MODE_READ) begin
            n_out_count = f_out(base);
        end else if (r_p3_bad) begin
            n_out_count = '0;
        end else begin
            n_out_count = f_out(n_count);
        end
        n_out_total = do_write ? f_out(n_total) : f_out(r_total);
    end

    always_comb begin
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = p3_move && do_write;
            mem_waddr = r_p3_addr;
            mem_wdata = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (p2_move) begin
            r_rd_data <= r_mem[r_p2_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= RAD_BITS'(4);
            r_spec      <= SPC_BITS'(8);
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_reg'(i_cfg_index))
                    REG_ALPHABET_SIZE: r_alpha <= i_cfg_data[RAD_BITS-1:0];
                    REG_SPECIES_COUNT: r_spec  <= i_cfg_data[SPC_BITS-1:0];
                    default: ;
                endcase
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + IDX_BITS'(1);
                if (&r_clr_addr) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (p1_free) begin
                r_p1_valid <= in_acc;
            end
            if (p2_free) begin
                r_p2_valid <= r_p1_valid;
            end
            if (p3_free) begin
                r_p3_valid <= r_p2_valid;
            end
            if (p2_move) begin
                r_fwd <= p3_move && do_write && (r_p3_addr == r_p2_addr);
            end
            if (p3_move && do_write) begin
                r_total <= n_total;
            end
            if (out_free) begin
                r_out_valid <= r_p3_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p1_mode <= t_mode'(s_axis_tuser);
            r_p1_bad  <= n_bad;
            r_p1_bidx <= s_axis_tdata[2*IDX_BITS-1:IDX_BITS];
            r_p1_term <= n_term;
        end
        if (p1_move) begin
            r_p2_mode <= r_p1_mode;
            r_p2_bad  <= r_p1_bad;
            r_p2_addr <= n_p2_addr;
        end
        if (p2_move) begin
            r_p3_mode  <= r_p2_mode;
            r_p3_bad   <= r_p2_bad;
            r_p3_addr  <= r_p2_addr;
            r_fwd_data <= n_count;
        end
        if (p3_move) begin
            r_out_count <= n_out_count;
            r_out_total <= n_out_total;
            r_out_bad   <= (r_p3_mode == MODE_COUNT) && r_p3_bad;
        end
    end

endmodule

// ===== hdl/sph_checker.sv =====
// Port-level checks for site_pattern_histogram, attached by bind.
// Depends on sph_pkg for the field widths.
module sph_assertions (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,   // bin_count, total_columns
    input logic        m_axis_tuser    // bad_symbol
);
    import sph_pkg::*;

    logic out_acc;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // no request accepted and no result offered during reset or the first cycle of the clearing pass
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("request traffic right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[OUT_BITS-1:0] == '0)
        else $error("rejected column reports a nonzero bin count");

    a_bin_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_BITS-1:0] <= m_axis_tdata[2*OUT_BITS-1:OUT_BITS])
        else $error("bin count exceeds column total");

    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc ##1 out_acc |->
            m_axis_tdata[2*OUT_BITS-1:OUT_BITS] >= $past(m_axis_tdata[2*OUT_BITS-1:OUT_BITS]))
        else $error("column total went backward");

endmodule

bind site_pattern_histogram sph_assertions u_sph_assertions (.*);

// ===== sim/sph_checker.sv =====
// Scoreboard for site_pattern_histogram: watches the config, input and result channels,
// keeps its own histogram and column total, and compares every result in request order.
// Depends on sph_pkg.
module sph_checker #(
    parameter int MAX_SPECIES = 8,
    parameter int COUNT_BITS  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,   // column_symbols, bin_index
    input  logic                         s_axis_tuser,   // mode
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [63:0]                  m_axis_tdata,   // bin_count, total_columns
    input  logic                         m_axis_tuser,   // bad_symbol
    input  logic                         i_cfg_valid,
    input  logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [sph_pkg::CFG_BITS-1:0] i_cfg_data,
    output int                           o_pending,
    output int                           o_fail_count
);
    import sph_pkg::*;

    typedef struct packed {
        logic [OUT_BITS-1:0] bin_count;
        logic [OUT_BITS-1:0] total_columns;
        logic                bad_symbol;
    } t_column_result;

    logic [COUNT_BITS-1:0] bin_store [0:(1 << IDX_BITS)-1];
    logic [COUNT_BITS-1:0] column_total;
    logic [RAD_BITS-1:0]   alphabet_reg;
    logic [SPC_BITS-1:0]   species_reg;
    t_column_result        result_q [$];
    t_column_result        want;
    int                    mismatches = 0;

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_BITS-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'(OUT_MAX)) ? OUT_MAX : w[OUT_BITS-1:0];
    endfunction

    // Returns a request's expected result; valid counts also update the histogram.
    function automatic t_column_result tally_request(input t_mode            mode,
                                                     input logic [IDX_BITS-1:0] syms,
                                                     input logic [IDX_BITS-1:0] bidx);
        logic [RAD_BITS-1:0] radix;
        int                  ns;
        int                  j;
        logic [31:0]         idx;
        logic [1:0]          s;
        logic                bad;
        t_column_result      r;
        radix = alphabet_reg;
        if (radix < RAD_BITS'(2)) radix = RAD_BITS'(2);
        if (radix > RAD_BITS'(4)) radix = RAD_BITS'(4);
        ns = int'(species_reg);
        if (ns < 1) ns = 1;
        if (ns > MAX_SPECIES) ns = MAX_SPECIES;
        if (mode == MODE_READ) begin
            r.bin_count     = clip_out(bin_store[bidx]);
            r.total_columns = clip_out(column_total);
            r.bad_symbol    = 1'b0;
            return r;
        end
        idx = '0;
        bad = 1'b0;
        for (j = 0; j < ns; j++) begin
            s = (j < IN_SLOTS) ? syms[SYM_BITS*j +: SYM_BITS] : 2'd0;
            if (s >= radix) bad = 1'b1;
            idx = idx * radix + s;
        end
        if (bad) begin
            r.bin_count     = '0;
            r.total_columns = clip_out(column_total);
            r.bad_symbol    = 1'b1;
            return r;
        end
        bin_store[idx[IDX_BITS-1:0]] = bump(bin_store[idx[IDX_BITS-1:0]]);
        column_total = bump(column_total);
        r.bin_count     = clip_out(bin_store[idx[IDX_BITS-1:0]]);
        r.total_columns = clip_out(column_total);
        r.bad_symbol    = 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < (1 << IDX_BITS); k++) bin_store[k] = '0;
            column_total = '0;
            alphabet_reg = 3'd4;
            species_reg  = 4'd8;
            result_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual tdata=%h tuser=%b",
                             $time, m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    if (m_axis_tdata[31:0] !== want.bin_count) begin
                        $display("%0t: bin_count: expected %0d, actual %0d",
                                 $time, want.bin_count, m_axis_tdata[31:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[63:32] !== want.total_columns) begin
                        $display("%0t: total_columns: expected %0d, actual %0d",
                                 $time, want.total_columns, m_axis_tdata[63:32]);
                        mismatches++;
                    end
                    if (m_axis_tuser !== want.bad_symbol) begin
                        $display("%0t: bad_symbol: expected %b, actual %b",
                                 $time, want.bad_symbol, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg'(i_cfg_index))
                    REG_ALPHABET_SIZE: alphabet_reg = i_cfg_data[RAD_BITS-1:0];
                    REG_SPECIES_COUNT: species_reg  = i_cfg_data[SPC_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                result_q.push_back(tally_request(t_mode'(s_axis_tuser),
                                                 s_axis_tdata[15:0], s_axis_tdata[31:16]));
            end
        end
        o_pending    <= result_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== sim/site_pattern_histogram_tb.sv =====
// Top of the site_pattern_histogram testbench: clock, reset, directed and random column and
// read requests, config phases and back-pressure. Depends on sph_pkg, site_pattern_histogram
// and sph_checker.
module site_pattern_histogram_tb;
    import sph_pkg::*;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [63:0]         m_axis_tdata;
    logic                m_axis_tuser;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index   = 1'b0;
    logic [CFG_BITS-1:0] i_cfg_data    = '0;

    int   pending;
    int   fail_count;
    logic steady       = 1'b0;
    int   hold_request = 0;
    int   alpha_raw    = 4;
    int   species_raw  = 8;
    logic [15:0] recent [4];

    site_pattern_histogram #(.MAX_SPECIES(8), .COUNT_BITS(32)) uut (.*);

    sph_checker #(.MAX_SPECIES(8), .COUNT_BITS(32)) tally_check (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_pending(pending), .o_fail_count(fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic int radix_now();
        int r;
        r = alpha_raw & 7;
        return (r < 2) ? 2 : (r > 4) ? 4 : r;
    endfunction

    function automatic int species_now();
        return (species_raw < 1) ? 1 : (species_raw > 8) ? 8 : species_raw;
    endfunction

    // Result side: random stalls, plus a long hold-off on request.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        int hold_seen;
        stall_left = 0;
        hold_left  = 0;
        hold_seen  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request != hold_seen) begin
                hold_left = 400;
                hold_seen = hold_request;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 20)
                    stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                             : $urandom_range(4, 30);
            end
        end
    end

    task automatic send_req(input t_mode mode, input logic [15:0] syms,
                            input logic [15:0] bidx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {bidx, syms};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Sender pause: wait for every outstanding result, then let the pipe empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_BITS-1:0] alpha,
                              input logic [CFG_BITS-1:0] species);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_ALPHABET_SIZE;
        i_cfg_data  <= alpha;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_SPECIES_COUNT;
        i_cfg_data  <= species;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        alpha_raw   = alpha;
        species_raw = species;
    endtask

    function automatic logic [15:0] good_column();
        logic [15:0] c;
        int          rad;
        rad = radix_now();
        for (int j = 0; j < 8; j++) c[2*j +: 2] = 2'($urandom_range(0, rad - 1));
        return c;
    endfunction

    task automatic run_mix(input int n);
        int          r;
        int          span;
        logic [15:0] c;
        span = 1;
        repeat (species_now()) span *= radix_now();
        if (span > 65536) span = 65536;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                if ($urandom_range(0, 99) < 30) begin
                    c = recent[$urandom_range(0, 3)];
                end else begin
                    c = good_column();
                    recent[$urandom_range(0, 3)] = c;
                end
                send_req(MODE_COUNT, c, 16'($urandom));
            end else if (r < 67) begin
                send_req(MODE_COUNT, 16'($urandom), 16'($urandom));
            end else if ($urandom_range(0, 99) < 75) begin
                send_req(MODE_READ, 16'($urandom), 16'($urandom_range(0, span - 1)));
            end else begin
                send_req(MODE_READ, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        for (int k = 0; k < 4; k++) recent[k] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: radix 4, eight species
        send_req(MODE_COUNT, 16'h0000, 16'h0000);
        send_req(MODE_COUNT, 16'hFFFF, 16'h0000);
        send_req(MODE_COUNT, 16'hFFFF, 16'h5A5A);
        send_req(MODE_READ,  16'hA5A5, 16'hFFFF);
        send_req(MODE_READ,  16'hFFFF, 16'h0000);
        send_req(MODE_READ,  16'h0000, 16'h1234);
        send_req(MODE_COUNT, 16'h1B1B, 16'hFFFF);
        settle();

        // binary alphabet, one species: upper symbols ignored, 2 and 3 are bad
        set_config(4'd2, 4'd1);
        send_req(MODE_COUNT, 16'h0000, 16'h0000);
        send_req(MODE_COUNT, 16'hFFFD, 16'h0000);
        send_req(MODE_COUNT, 16'h0002, 16'h0000);
        send_req(MODE_COUNT, 16'h0003, 16'h0000);
        send_req(MODE_READ,  16'h0000, 16'h0001);
        settle();

        set_config(4'd3, 4'd5);
        send_req(MODE_COUNT, 16'h02AA, 16'h0000);
        send_req(MODE_COUNT, 16'h0300, 16'h0000);
        send_req(MODE_READ,  16'h0000, 16'd242);
        settle();

        // alphabet writes are 3 bits wide: 8 reads as 0, clamps to 2; species 0 acts as 1
        set_config(4'h8, 4'h0);
        send_req(MODE_COUNT, 16'h0001, 16'h0000);
        send_req(MODE_COUNT, 16'h0002, 16'h0000);
        send_req(MODE_READ,  16'h0000, 16'h0001);
        settle();

        set_config(4'hF, 4'hF);
        send_req(MODE_COUNT, 16'hFFFF, 16'h0000);
        send_req(MODE_READ,  16'h0000, 16'hFFFF);
        settle();

        set_config(4'd5, 4'd9);
        send_req(MODE_COUNT, 16'hE4E4, 16'h0000);
        send_req(MODE_READ,  16'h0000, 16'h1B1B);
        settle();

        // long result hold-off while requests keep coming
        set_config(4'd4, 4'd2);
        steady       = 1'b1;
        hold_request = hold_request + 1;
        run_mix(60);
        steady = 1'b0;
        settle();

        for (int p = 0; p < 12; p++) begin
            set_config(($urandom_range(0, 99) < 70) ? 4'($urandom_range(2, 4))
                                                   : 4'($urandom_range(0, 15)),
                       ($urandom_range(0, 99) < 60) ? 4'($urandom_range(1, 4)) :
                       ($urandom_range(0, 99) < 60) ? 4'($urandom_range(5, 8))
                                                   : 4'($urandom_range(0, 15)));
            steady = (p % 4 == 1);
            run_mix($urandom_range(110, 160));
            steady = 1'b0;
            settle();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sph_pkg.sv
hdl/site_pattern_histogram.sv
hdl/sph_checker.sv
sim/sph_checker.sv
sim/site_pattern_histogram_tb.sv
